### hw/rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hw/rtl/cau_pkg.sv
// ------------------------------------------------------------------------
// cau_pkg
// Constants, opcodes and square-root step for the complex arithmetic unit.
// ------------------------------------------------------------------------
package cau_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int OP_W       = 3;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_SCR = 3'd3;
	localparam logic [OP_W-1:0] OP_SCI = 3'd4;
	localparam logic [OP_W-1:0] OP_MAG = 3'd5;

	localparam int MUL_W     = DATA_WIDTH + 1;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int RES_W     = SUM_W - FRAC_BITS;
	localparam int RAD_W     = 2 * DATA_WIDTH;
	localparam int ROOT_W    = DATA_WIDTH;
	localparam int REM_W     = ROOT_W + 2;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	function automatic sq_state_t sqrt_step(sq_state_t st, logic [1:0] pair);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		sq_state_t        o;
		r = {st.rem[REM_W-3:0], pair};
		t = {st.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction
endpackage

### hw/rtl/cau_req_if.sv
// ------------------------------------------------------------------------
// cau_req_if
// Request channel: opcode, two complex operands and a scale factor.
// ------------------------------------------------------------------------
interface cau_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [cau_pkg::OP_W-1:0]               opcode;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  scalar;

	modport source(output valid, opcode, a_re, a_im, b_re, b_im, scalar, input ready);
	modport sink(input valid, opcode, a_re, a_im, b_re, b_im, scalar, output ready);
endinterface

### hw/rtl/cau_rsp_if.sv
// ------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result and overflow flag.
// ------------------------------------------------------------------------
interface cau_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  res_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0]  res_im;
	logic                                   overflow;

	modport source(output valid, res_re, res_im, overflow, input ready);
	modport sink(input valid, res_re, res_im, overflow, output ready);
endinterface

### hw/rtl/complex_arithmetic_unit.sv
// ------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, scale, magnitude.
// ------------------------------------------------------------------------
// Every opcode passes all stages, the square-root stages included.
// Throughput: one item per cycle; the whole pipe stalls only when the
// output register is full and not taken. Depth is set by the square root,
// four result bits per stage. arst_n clears all valid bits at once.
`include "assert_macros.svh"

module complex_arithmetic_unit (
	input  logic       clk,
	input  logic       arst_n,
	cau_req_if.sink    req,
	cau_rsp_if.source  rsp
);
	localparam int DW     = cau_pkg::DATA_WIDTH;
	localparam int F      = cau_pkg::FRAC_BITS;
	localparam int MW     = cau_pkg::MUL_W;
	localparam int PW     = cau_pkg::PROD_W;
	localparam int SW     = cau_pkg::SUM_W;
	localparam int RW     = cau_pkg::RES_W;
	localparam int AW     = cau_pkg::RAD_W;
	localparam int QW     = cau_pkg::ROOT_W;
	localparam int NSTG   = cau_pkg::SQ_STAGES;
	localparam int NSTEP  = cau_pkg::SQ_STEPS;
	localparam int OPW    = cau_pkg::OP_W;

	localparam logic signed [RW-1:0] RMAX = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [RW-1:0] RMIN = {{(RW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

	logic adv;
	logic vld_q;

	assign adv       = !vld_q || rsp.ready;
	assign req.ready = adv;

	// stage 1: input register
	logic                 vld_s1;
	logic [OPW-1:0]       op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1, sc_s1;

	// stage 2: products
	logic                 vld_s2;
	logic [OPW-1:0]       op_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [MW-1:0] asr_s2, asi_s2;

	// stage 3: sums, floor shift, radicand
	logic                 vld_s3;
	logic [OPW-1:0]       op_s3;
	logic signed [RW-1:0] re_s3, im_s3;
	logic [AW-1:0]        rad_s3;

	// square-root stages
	logic                 vld_sq [NSTG];
	logic [OPW-1:0]       op_sq  [NSTG];
	logic signed [RW-1:0] re_sq  [NSTG];
	logic signed [RW-1:0] im_sq  [NSTG];
	logic [AW-1:0]        rad_sq [NSTG];
	cau_pkg::sq_state_t   st_sq  [NSTG];

	// output register
	logic [OPW-1:0]       op_q;
	logic signed [DW-1:0] res_re_q, res_im_q;
	logic                 ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_sq[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= req.opcode;
			ar_s1 <= req.a_re;
			ai_s1 <= req.a_im;
			br_s1 <= req.b_re;
			bi_s1 <= req.b_im;
			sc_s1 <= req.scalar;
		end
	end

	logic signed [MW-1:0] ar_x, ai_x, br_x, bi_x, sc_x, ur_x, ui_x;
	logic signed [MW-1:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;

	always_comb begin
		ar_x = MW'(ar_s1);
		ai_x = MW'(ai_s1);
		br_x = MW'(br_s1);
		bi_x = MW'(bi_s1);
		sc_x = MW'(sc_s1);
		ur_x = ar_x[MW-1] ? -ar_x : ar_x;
		ui_x = ai_x[MW-1] ? -ai_x : ai_x;
		m0a = '0; m0b = '0; m1a = '0; m1b = '0;
		m2a = '0; m2b = '0; m3a = '0; m3b = '0;
		unique case (op_s1)
			cau_pkg::OP_MUL: begin
				m0a = ar_x; m0b = br_x; m1a = ai_x; m1b = bi_x;
				m2a = ar_x; m2b = bi_x; m3a = ai_x; m3b = br_x;
			end
			cau_pkg::OP_SCR: begin
				m0a = ar_x; m0b = sc_x; m1a = ai_x; m1b = sc_x;
			end
			cau_pkg::OP_SCI: begin
				m0a = ai_x; m0b = sc_x; m1a = ar_x; m1b = sc_x;
			end
			cau_pkg::OP_MAG: begin
				m0a = ur_x; m0b = ur_x; m1a = ui_x; m1b = ui_x;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2  <= op_s1;
			p0_s2  <= m0a * m0b;
			p1_s2  <= m1a * m1b;
			p2_s2  <= m2a * m2b;
			p3_s2  <= m3a * m3b;
			asr_s2 <= (op_s1 == cau_pkg::OP_SUB) ? ar_x - br_x : ar_x + br_x;
			asi_s2 <= (op_s1 == cau_pkg::OP_SUB) ? ai_x - bi_x : ai_x + bi_x;
		end
	end

	logic signed [SW-1:0] sre, sim;
	logic signed [RW-1:0] re_n, im_n;
	logic [SW-1:0]        sre_sh, sim_sh;

	always_comb begin
		sre = '0;
		sim = '0;
		unique case (op_s2)
			cau_pkg::OP_MUL: begin
				sre = SW'(p0_s2) - SW'(p1_s2);
				sim = SW'(p2_s2) + SW'(p3_s2);
			end
			cau_pkg::OP_SCR: begin
				sre = SW'(p0_s2);
				sim = SW'(p1_s2);
			end
			cau_pkg::OP_SCI: begin
				sre = -SW'(p0_s2);
				sim = SW'(p1_s2);
			end
			default: begin
			end
		endcase
		sre_sh = sre >>> F;
		sim_sh = sim >>> F;
		if (op_s2 == cau_pkg::OP_ADD || op_s2 == cau_pkg::OP_SUB) begin
			re_n = RW'(asr_s2);
			im_n = RW'(asi_s2);
		end else begin
			re_n = sre_sh[RW-1:0];
			im_n = sim_sh[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3  <= op_s2;
			re_s3  <= re_n;
			im_s3  <= im_n;
			rad_s3 <= AW'(p0_s2 + p1_s2);
		end
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_sq
		logic               vld_in;
		logic [OPW-1:0]     op_in;
		logic signed [RW-1:0] re_in, im_in;
		logic [AW-1:0]      rad_in, rad_nx;
		cau_pkg::sq_state_t st_in, st_nx;

		if (k == 0) begin : g_first
			assign vld_in = vld_s3;
			assign op_in  = op_s3;
			assign re_in  = re_s3;
			assign im_in  = im_s3;
			assign rad_in = rad_s3;
			assign st_in  = '0;
		end else begin : g_next
			assign vld_in = vld_sq[k-1];
			assign op_in  = op_sq[k-1];
			assign re_in  = re_sq[k-1];
			assign im_in  = im_sq[k-1];
			assign rad_in = rad_sq[k-1];
			assign st_in  = st_sq[k-1];
		end

		always_comb begin
			st_nx  = st_in;
			rad_nx = rad_in;
			for (int j = 0; j < NSTEP; j++) begin
				st_nx  = cau_pkg::sqrt_step(st_nx, rad_nx[AW-1 -: 2]);
				rad_nx = {rad_nx[AW-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[k] <= 1'b0;
			end else if (adv) begin
				vld_sq[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_sq[k]  <= op_in;
				re_sq[k]  <= re_in;
				im_sq[k]  <= im_in;
				rad_sq[k] <= rad_nx;
				st_sq[k]  <= st_nx;
			end
		end
	end

	logic signed [RW-1:0] fre, fim;
	logic [QW-1:0]        root;
	logic [DW-1:0]        o_re, o_im;
	logic                 o_ovf;

	always_comb begin
		fre   = re_sq[NSTG-1];
		fim   = im_sq[NSTG-1];
		root  = st_sq[NSTG-1].root;
		o_ovf = 1'b0;
		if (op_sq[NSTG-1] == cau_pkg::OP_MAG) begin
			o_im = '0;
			if (root > QW'(VMAX)) begin
				o_re  = VMAX;
				o_ovf = 1'b1;
			end else begin
				o_re = DW'(root);
			end
		end else begin
			if (fre > RMAX) begin
				o_re  = RMAX[DW-1:0];
				o_ovf = 1'b1;
			end else if (fre < RMIN) begin
				o_re  = RMIN[DW-1:0];
				o_ovf = 1'b1;
			end else begin
				o_re = fre[DW-1:0];
			end
			if (fim > RMAX) begin
				o_im  = RMAX[DW-1:0];
				o_ovf = 1'b1;
			end else if (fim < RMIN) begin
				o_im  = RMIN[DW-1:0];
				o_ovf = 1'b1;
			end else begin
				o_im = fim[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_q     <= op_sq[NSTG-1];
			res_re_q <= o_re;
			res_im_q <= o_im;
			ovf_q    <= o_ovf;
		end
	end

	assign rsp.valid    = vld_q;
	assign rsp.res_re   = res_re_q;
	assign rsp.res_im   = res_im_q;
	assign rsp.overflow = ovf_q;

	logic mag_out;
	logic re_at_lim;
	logic im_at_lim;
	logic unused_out;

	assign mag_out    = rsp.valid && op_q == cau_pkg::OP_MAG;
	assign re_at_lim  = rsp.res_re == RMAX[DW-1:0] || rsp.res_re == RMIN[DW-1:0];
	assign im_at_lim  = rsp.res_im == RMAX[DW-1:0] || rsp.res_im == RMIN[DW-1:0];
	assign unused_out = rsp.valid && op_q > cau_pkg::OP_MAG;

	`ASSERT_ALWAYS(a_mag_im_zero, clk, arst_n, mag_out |-> rsp.res_im == '0)
	`ASSERT_ALWAYS(a_ovf_at_limit, clk, arst_n, rsp.valid && rsp.overflow |-> re_at_lim || im_at_lim)
	`ASSERT_NEVER(a_unused_op_zero, clk, arst_n, unused_out && (rsp.overflow || rsp.res_re != '0 || rsp.res_im != '0))
endmodule
